// File: rtl/oms_pkg.sv
// Shared types and constants for the online mean / scatter update unit.
// No dependencies; every other file but oms_div uses this package by scoped names.
package oms_pkg;

  localparam int unsigned MaxDim = 4;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] sample_3;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_0;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [63:0] variance_value;
    logic               invalid;
    logic               last;
  } out_t;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_READ    = 1'b1
  } op_e;

  // Control handed from the top level to every lane.
  typedef struct packed {
    logic        start;
    op_e         op;
    logic [2:0]  dim;
    logic [32:0] n;
    logic [32:0] den;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
  } lane_stat_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MDIV_GO, L_MDIV_WAIT, L_MUL, L_PDIV_GO, L_PDIV_WAIT, L_RDIV_GO, L_RDIV_WAIT
  } lane_st_e;

  typedef enum logic [1:0] {
    T_IDLE, T_RUN, T_EMIT
  } top_st_e;

endpackage

// File: rtl/oms_div.sv
// Restoring unsigned divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// Standalone; used by each lane of the update unit.
module oms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] sh;
  logic [33:0] diff;

  always_comb begin
    sh     = {rem_q, num_q[63]};
    diff   = sh - {1'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[32:0];
        num_d = {num_q[62:0], 1'b1};
      end else begin
        rem_d = sh[32:0];
        num_d = {num_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// File: rtl/oms_lane.sv
// One lane: owns one mean element and one row of the scatter matrix.
// Depends on oms_pkg and oms_div.
module oms_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  oms_pkg::lane_ctl_t               ctl_i,
  input  logic signed [31:0]               sample_i,
  input  logic [oms_pkg::MaxDim-1:0][32:0] diff_all_i,
  output logic [32:0]                      diff_o,
  output oms_pkg::lane_stat_t              stat_o,
  output logic [oms_pkg::MaxDim-1:0][63:0] res_o
);

  oms_pkg::lane_st_e state_q, state_d;
  oms_pkg::op_e      op_q;
  logic [2:0]        dim_q;
  logic [32:0]       n_q, den_q;
  logic [1:0]        j_q;
  logic signed [32:0] diff_q;
  logic signed [31:0] mean_q;
  logic [oms_pkg::MaxDim-1:0][63:0] row_q;
  logic [oms_pkg::MaxDim-1:0][63:0] res_q;
  logic [63:0]       prod_q;
  logic              neg_q;

  logic        div_start, div_done, last_j;
  logic [63:0] div_num, div_quo;
  logic [32:0] div_den;
  logic [31:0] abs_i, abs_j;
  logic signed [32:0] dj;
  logic signed [63:0] row_sel;
  logic [63:0] abs_row, mag;
  logic signed [33:0] qs, msum;
  logic signed [65:0] acc;
  logic signed [63:0] acc_sat;

  assign last_j  = ({1'b0, j_q} == (dim_q - 3'd1));
  assign dj      = diff_all_i[j_q];
  assign abs_i   = diff_q[32] ? 32'(-diff_q) : diff_q[31:0];
  assign abs_j   = dj[32] ? 32'(-dj) : dj[31:0];
  assign row_sel = row_q[j_q];
  assign abs_row = row_sel[63] ? 64'(-row_sel) : row_sel;
  assign mag     = prod_q - div_quo;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oms_pkg::L_IDLE:
        if (ctl_i.start)
          state_d = (ctl_i.op == oms_pkg::OP_READ) ? oms_pkg::L_RDIV_GO : oms_pkg::L_MDIV_GO;
      oms_pkg::L_MDIV_GO:   state_d = oms_pkg::L_MDIV_WAIT;
      oms_pkg::L_MDIV_WAIT: if (div_done) state_d = oms_pkg::L_MUL;
      oms_pkg::L_MUL:       state_d = oms_pkg::L_PDIV_GO;
      oms_pkg::L_PDIV_GO:   state_d = oms_pkg::L_PDIV_WAIT;
      oms_pkg::L_PDIV_WAIT:
        if (div_done) state_d = last_j ? oms_pkg::L_IDLE : oms_pkg::L_MUL;
      oms_pkg::L_RDIV_GO:   state_d = oms_pkg::L_RDIV_WAIT;
      oms_pkg::L_RDIV_WAIT:
        if (div_done) state_d = last_j ? oms_pkg::L_IDLE : oms_pkg::L_RDIV_GO;
      default:              state_d = oms_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    div_start   = 1'b0;
    div_num     = abs_row;
    stat_o.busy = (state_q != oms_pkg::L_IDLE);
    unique case (state_q)
      oms_pkg::L_MDIV_GO: begin
        div_start = 1'b1;
        div_num   = {32'd0, abs_i};
      end
      oms_pkg::L_PDIV_GO: begin
        div_start = 1'b1;
        div_num   = prod_q;
      end
      oms_pkg::L_RDIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  assign div_den = (op_q == oms_pkg::OP_READ) ? den_q : n_q;

  // Mean step: the quotient never exceeds the difference, but clamp anyway.
  always_comb begin
    qs   = diff_q[32] ? -$signed({1'b0, div_quo[32:0]}) : $signed({1'b0, div_quo[32:0]});
    msum = 34'(mean_q) + qs;
    // Scatter step: add k/n * d_i * d_j with its sign, saturating.
    acc = neg_q ? (66'(row_sel) - $signed({2'b00, mag}))
                : (66'(row_sel) + $signed({2'b00, mag}));
    if (acc > 66'sh0_7FFF_FFFF_FFFF_FFFF)       acc_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (acc < -66'sh0_8000_0000_0000_0000) acc_sat = 64'sh8000_0000_0000_0000;
    else                                        acc_sat = acc[63:0];
  end

  oms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oms_pkg::L_IDLE;
      mean_q  <= '0;
      row_q   <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == oms_pkg::L_IDLE && ctl_i.start) begin
        j_q <= '0;
      end else if (state_q == oms_pkg::L_MDIV_WAIT && div_done) begin
        if (msum > 34'sd2147483647)       mean_q <= 32'sh7FFF_FFFF;
        else if (msum < -34'sd2147483648) mean_q <= 32'sh8000_0000;
        else                              mean_q <= msum[31:0];
      end else if (state_q == oms_pkg::L_PDIV_WAIT && div_done) begin
        row_q[j_q] <= acc_sat;
        j_q        <= j_q + 2'd1;
      end else if (state_q == oms_pkg::L_RDIV_WAIT && div_done) begin
        j_q <= j_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == oms_pkg::L_IDLE && ctl_i.start) begin
      op_q   <= ctl_i.op;
      dim_q  <= ctl_i.dim;
      n_q    <= ctl_i.n;
      den_q  <= ctl_i.den;
      diff_q <= 33'(sample_i) - 33'(mean_q);
    end
    if (state_q == oms_pkg::L_MUL) begin
      prod_q <= abs_i * abs_j;
      neg_q  <= diff_q[32] ^ dj[32];
    end
    if (state_q == oms_pkg::L_RDIV_WAIT && div_done)
      res_q[j_q] <= row_sel[63] ? 64'(-div_quo) : div_quo;
  end

  assign diff_o = diff_q;
  assign res_o  = res_q;

endmodule

// File: rtl/online_mean_scatter_update_unit.sv
// Top level of the online mean / scatter update unit: lanes, control, readout.
// Depends on oms_pkg, oms_lane and oms_div.
//
// Usage: items arrive on the in channel (valid/ready). An observe transaction
// folds one sample vector into the running mean, the scatter matrix and the
// observation count; it produces no output. A read transaction produces dim*dim
// output transactions in row-major order carrying the variance entries, with
// last set on the final one and invalid set when there are too few samples.
// Each of the dim lanes owns one mean element and one scatter row and runs in
// parallel with the others; each lane step runs through a serial divider.
// An observe runs a mean division and then, per column, a multiply and a
// scatter division; a read runs one division per column in every lane, then
// emits one entry per cycle while the receiver keeps ready high.
// One item is in flight at a time; in_ready is high only while idle.
// If the receiver stalls, the current entry is held until it is taken.
// Reset clears the mean, scatter matrix and count, and sets dim_in_use to 4.
// dim_in_use is written through cfg_we_i / cfg_data_i; write it only while idle (not enforced by the block).
module online_mean_scatter_update_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  oms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output oms_pkg::out_t out_data_o
);

  oms_pkg::top_st_e state_q, state_d;
  logic [2:0]  dim_cfg_q, dim_q, dim_use;
  logic [31:0] count_q;
  oms_pkg::op_e op_q;
  logic        bad_q, bad;
  logic [1:0]  r_q, c_q;
  logic        accept, any_busy, last_ent;
  logic [32:0] den;
  oms_pkg::lane_ctl_t ctl;
  logic [oms_pkg::MaxDim-1:0]            lane_busy;
  logic [oms_pkg::MaxDim-1:0][32:0]      diffs;
  logic [oms_pkg::MaxDim-1:0][31:0]      samples;
  logic [oms_pkg::MaxDim-1:0][oms_pkg::MaxDim-1:0][63:0] res;
  oms_pkg::lane_stat_t stat [oms_pkg::MaxDim];
  logic [63:0] res_sel;

  always_comb begin
    if (dim_cfg_q == 3'd0)      dim_use = 3'd1;
    else if (dim_cfg_q > 3'd4)  dim_use = 3'd4;
    else                        dim_use = dim_cfg_q;
  end

  assign bad     = ({1'b0, count_q} <= (33'(dim_use) + 33'd2));
  assign den     = bad ? 33'd1 : ({1'b0, count_q} - 33'd2 - 33'(dim_use));
  assign accept  = in_valid_i && in_ready_o;
  assign samples = {in_data_i.sample_3, in_data_i.sample_2,
                    in_data_i.sample_1, in_data_i.sample_0};

  always_comb begin
    ctl.start = accept;
    ctl.op    = oms_pkg::op_e'(in_data_i.operation);
    ctl.dim   = dim_use;
    ctl.n     = {1'b0, count_q} + 33'd1;
    ctl.den   = den;
  end

  for (genvar g = 0; g < oms_pkg::MaxDim; g++) begin : g_lane
    oms_pkg::lane_ctl_t lctl;
    always_comb begin
      lctl       = ctl;
      lctl.start = ctl.start && (3'(g) < dim_use);
    end
    oms_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lctl),
      .sample_i  (samples[g]),
      .diff_all_i(diffs),
      .diff_o    (diffs[g]),
      .stat_o    (stat[g]),
      .res_o     (res[g])
    );
    assign lane_busy[g] = stat[g].busy;
  end

  assign any_busy = |lane_busy;
  assign last_ent = ({1'b0, r_q} == dim_q - 3'd1) && ({1'b0, c_q} == dim_q - 3'd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oms_pkg::T_IDLE: if (accept) state_d = oms_pkg::T_RUN;
      oms_pkg::T_RUN:
        if (!any_busy)
          state_d = (op_q == oms_pkg::OP_READ) ? oms_pkg::T_EMIT : oms_pkg::T_IDLE;
      oms_pkg::T_EMIT: if (out_ready_i && last_ent) state_d = oms_pkg::T_IDLE;
      default: state_d = oms_pkg::T_IDLE;
    endcase
  end

  assign res_sel = res[r_q][c_q];

  always_comb begin
    in_ready_o                = (state_q == oms_pkg::T_IDLE);
    out_valid_o               = (state_q == oms_pkg::T_EMIT);
    out_data_o.row_index      = r_q;
    out_data_o.col_index      = c_q;
    out_data_o.variance_value = bad_q ? 64'sd0 : res_sel;
    out_data_o.invalid        = bad_q;
    out_data_o.last           = last_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= oms_pkg::T_IDLE;
      dim_cfg_q <= 3'd4;
      count_q   <= '0;
      op_q      <= oms_pkg::OP_OBSERVE;
      r_q       <= '0;
      c_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dim_cfg_q <= cfg_data_i;
      if (accept) begin
        op_q <= ctl.op;
        r_q  <= '0;
        c_q  <= '0;
      end
      if (state_q == oms_pkg::T_RUN && !any_busy && op_q == oms_pkg::OP_OBSERVE
          && count_q != 32'hFFFF_FFFF)
        count_q <= count_q + 32'd1;
      if (state_q == oms_pkg::T_EMIT && out_ready_i) begin
        if ({1'b0, c_q} == dim_q - 3'd1) begin
          c_q <= '0;
          r_q <= r_q + 2'd1;
        end else begin
          c_q <= c_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dim_q <= dim_use;
      bad_q <= bad;
    end
  end

endmodule

// File: tb/oms_scoreboard.sv
// Checker for the online mean / scatter update unit: tracks the accumulator
// state, predicts readout entries and compares them. Depends on oms_pkg.
module oms_scoreboard (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  oms_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  oms_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  logic [2:0]         dim_reg;
  logic signed [31:0] mean_q [4];
  logic [63:0]        scatter_q [16];
  logic [31:0]        count_q;
  oms_pkg::out_t      entry_queue [$];

  function automatic int active_lanes();
    if (dim_reg < 1) return 1;
    if (dim_reg > oms_pkg::MaxDim) return oms_pkg::MaxDim;
    return dim_reg;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] acc, logic neg, logic [63:0] mag);
    logic [63:0] room;
    if (!neg) begin
      room = 64'h7fffffffffffffff - acc;
      return (mag > room) ? 64'h7fffffffffffffff : acc + mag;
    end
    room = acc - 64'h8000000000000000;
    return (mag > room) ? 64'h8000000000000000 : acc - mag;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  task automatic observe_sample(oms_pkg::in_t s);
    logic signed [63:0] diff [4];
    logic signed [31:0] lanes [4];
    logic signed [63:0] m;
    logic [63:0] n, ai, aj, p;
    int d;
    d = active_lanes();
    lanes = '{s.sample_0, s.sample_1, s.sample_2, s.sample_3};
    n = {32'd0, count_q} + 64'd1;
    for (int i = 0; i < d; i++) diff[i] = 64'(lanes[i]) - 64'(mean_q[i]);
    for (int i = 0; i < d; i++) begin
      m = 64'(mean_q[i]) + diff[i] / $signed(n);
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
      mean_q[i] = m[31:0];
    end
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++) begin
        ai = diff[i][63] ? -diff[i] : diff[i];
        aj = diff[j][63] ? -diff[j] : diff[j];
        p = ai * aj;
        scatter_q[i*4+j] = add_sat(scatter_q[i*4+j], diff[i][63] ^ diff[j][63], p - p / n);
      end
    if (count_q != 32'hffffffff) count_q++;
  endtask

  task automatic predict_readout();
    int d;
    logic bad;
    logic signed [63:0] den;
    oms_pkg::out_t e;
    d = active_lanes();
    bad = {32'd0, count_q} <= 64'(d + 2);
    den = bad ? 64'sd1 : 64'({32'd0, count_q}) - 64'(d + 2);
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++) begin
        e.row_index = i[1:0];
        e.col_index = j[1:0];
        e.variance_value = bad ? 64'sd0 : $signed(scatter_q[i*4+j]) / den;
        e.invalid = bad;
        e.last = (i == d - 1) && (j == d - 1);
        entry_queue.push_back(e);
      end
  endtask

  // A transaction accepted at the same edge as a configuration write still
  // sees the old dimension, as the unit does.
  always @(posedge clk_i or negedge rst_ni) begin
    oms_pkg::out_t e;
    if (!rst_ni) begin
      dim_reg = 3'd4;
      count_q = '0;
      for (int i = 0; i < 4; i++) mean_q[i] = '0;
      for (int i = 0; i < 16; i++) scatter_q[i] = '0;
      fail_count_o = 0;
      entry_queue.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (oms_pkg::op_e'(in_data_i.operation) == oms_pkg::OP_OBSERVE)
          observe_sample(in_data_i);
        else
          predict_readout();
      end
      if (cfg_we_i) dim_reg = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (entry_queue.size() == 0) begin
          report_mismatch("unexpected entry", out_data_i.variance_value, 0);
        end else begin
          e = entry_queue.pop_front();
          if (out_data_i.row_index != e.row_index)
            report_mismatch("row_index", out_data_i.row_index, e.row_index);
          if (out_data_i.col_index != e.col_index)
            report_mismatch("col_index", out_data_i.col_index, e.col_index);
          if (out_data_i.variance_value !== e.variance_value)
            report_mismatch("variance_value", out_data_i.variance_value, e.variance_value);
          if (out_data_i.invalid !== e.invalid)
            report_mismatch("invalid", out_data_i.invalid, e.invalid);
          if (out_data_i.last !== e.last)
            report_mismatch("last", out_data_i.last, e.last);
        end
      end
    end
    pending_o = entry_queue.size();
  end
endmodule

// File: tb/online_mean_scatter_update_unit_tb.sv
// Stimulus and verdict for the online mean / scatter update unit.
// Depends on oms_pkg, online_mean_scatter_update_unit and oms_scoreboard.
module online_mean_scatter_update_unit_tb;

  logic clk_i, rst_ni, cfg_we_i, in_valid_i, in_ready_o, out_valid_o;
  logic out_ready_i = 1'b1;
  logic [2:0] cfg_data_i;
  oms_pkg::in_t  in_data_i;
  oms_pkg::out_t out_data_o;
  int   fail_count, pending, idle_pct, stall_pct;
  int   stall_cycles = 0;

  online_mean_scatter_update_unit u_dut (.*);

  oms_scoreboard u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o),
    .in_data_i, .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls at the current rate.
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  // Watchdog on cycles without any transaction; it ends the run on its own.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(131072))) - 32'sd65536;
      default: return $signed($urandom());
    endcase
  endfunction

  // Valid drops after each transaction; the unit is
  // busy then anyway.
  task automatic send_item(oms_pkg::op_e op, logic signed [31:0] s0, logic signed [31:0] s1,
                           logic signed [31:0] s2, logic signed [31:0] s3);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{operation: op, sample_3: s3, sample_2: s2, sample_1: s1, sample_0: s0};
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random();
    send_item(($urandom_range(5) == 0) ? oms_pkg::OP_READ : oms_pkg::OP_OBSERVE,
              pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  // Writes a new dimension once all readout entries are out and the unit idles.
  task automatic set_dim(logic [2:0] d);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    rst_ni = 0; cfg_we_i = 0; cfg_data_i = '0; in_valid_i = 0; in_data_i = '0;
    idle_pct = 0; stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: read on an empty unit, extremes, count at the invalid boundary.
    send_item(oms_pkg::OP_READ, 32'sh7fffffff, 32'sh80000000, -1, 0);
    send_item(oms_pkg::OP_OBSERVE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000);
    send_item(oms_pkg::OP_OBSERVE, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff);
    for (int i = 0; i < 4; i++) begin
      send_item(oms_pkg::OP_OBSERVE, -1, 32'sh00010000, 0, 32'sh5555aaaa);
      send_item(oms_pkg::OP_READ, 0, 0, 0, 0);
    end
    set_dim(3'd0);
    for (int i = 0; i < 4; i++) send_item(oms_pkg::OP_OBSERVE, 32'sh7fffffff, -1, -1, -1);
    send_item(oms_pkg::OP_READ, -1, -1, -1, -1);
    set_dim(3'd7);
    send_item(oms_pkg::OP_READ, 0, 0, 0, 0);
    // Random part across dimensions and idling phases.
    for (int ph = 0; ph < 8; ph++) begin
      set_dim(3'(ph % 8));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int i = 0; i < 39; i++) send_random();
      send_item(oms_pkg::OP_READ, 0, 0, 0, 0);
    end
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
